// ===== hdl/abl_pkg.sv =====
// Shared types and constants of the ARP binding learn table.
package abl_pkg;

	// Payload widths of the input and result beats.
	localparam int unsigned IP_W    = 32;
	localparam int unsigned MAC_W   = 48;
	localparam int unsigned ENTRY_W = 9;

	// First MAC byte value that marks a MAC as unusable.
	localparam logic [7:0] MAC_BAD_BYTE = 8'h00;

	typedef logic [1:0] status_t;

	// Result status codes.
	localparam status_t ST_KNOWN  = 2'd0;
	localparam status_t ST_ADDED  = 2'd1;
	localparam status_t ST_REJECT = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

endpackage

// ===== hdl/abl_mem.sv =====
// Binding storage: one write port and one registered read port for the IPv4 addresses.
module abl_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned IDX_W = 8
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_addr,
	input  logic [abl_pkg::IP_W-1:0]  wr_ip,
	input  logic [abl_pkg::MAC_W-1:0] wr_mac,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_addr,
	output logic [abl_pkg::IP_W-1:0]  rd_ip
);
	import abl_pkg::*;

	logic [IP_W-1:0]  ip_mem  [DEPTH];
	logic [MAC_W-1:0] mac_mem [DEPTH];
	logic [IP_W-1:0]  rd_ip_q;

	// Write the learned pair into both arrays.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[wr_addr]  <= wr_ip;
			mac_mem[wr_addr] <= wr_mac;
		end
	end

	// Registered read of the address array for the scan.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ip_q <= ip_mem[rd_addr];
		end
	end

	assign rd_ip = rd_ip_q;

endmodule

// ===== hdl/abl_seq.sv =====
// Scan sequencer: walks the filled entries through one shared comparator and decides the result.
module abl_seq #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned IDX_W = 8,
	parameter int unsigned CNT_W = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [abl_pkg::IP_W-1:0]    ipv4_addr,
	input  logic [abl_pkg::MAC_W-1:0]   mac_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output abl_pkg::status_t            status,
	output logic [abl_pkg::ENTRY_W-1:0] entry_number,
	output logic                        wr_en,
	output logic [IDX_W-1:0]            wr_addr,
	output logic [abl_pkg::IP_W-1:0]    wr_ip,
	output logic [abl_pkg::MAC_W-1:0]   wr_mac,
	output logic                        rd_en,
	output logic [IDX_W-1:0]            rd_addr,
	input  logic [abl_pkg::IP_W-1:0]    rd_ip
);
	import abl_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	localparam int unsigned NUM_W = CNT_W + ENTRY_W + 1;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               pend_q;
	logic               hit_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [ENTRY_W-1:0] number_q;

	logic               in_take;
	logic               out_take;
	logic               issue;
	logic               match;
	logic               hit_next;
	logic               out_free;
	logic               is_full;
	logic               mac_bad;
	logic               add_now;
	logic [NUM_W-1:0]   num_wide;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Shared comparator on the entry read back last cycle.
	assign match    = pend_q && (rd_ip == ip_q);
	assign hit_next = hit_q || match;

	// One read is issued per cycle while filled entries remain.
	assign issue   = (state_q == S_SCAN) && (idx_q < count_q);
	assign rd_en   = issue;
	assign rd_addr = idx_q[IDX_W-1:0];

	// Decision terms for a new address.
	assign mac_bad  = (mac_q[MAC_W-1 -: 8] == MAC_BAD_BYTE);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign add_now  = (state_q == S_DECIDE) && out_free && !hit_q && !mac_bad && !is_full;
	assign num_wide = NUM_W'(count_q) + NUM_W'(1);

	// Append port into the storage.
	assign wr_en   = add_now;
	assign wr_addr = count_q[IDX_W-1:0];
	assign wr_ip   = ip_q;
	assign wr_mac  = mac_q;

	// Latch the input beat.
	always_ff @(posedge clk) begin
		if (in_take) begin
			ip_q  <= ipv4_addr;
			mac_q <= mac_addr;
		end
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						hit_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					// The last compare folds into hit_q on the cycle the scan ends.
					hit_q  <= hit_next;
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (add_now) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register: holds the beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DECIDE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, known first, then rejected MAC, then full.
	always_ff @(posedge clk) begin
		if ((state_q == S_DECIDE) && out_free) begin
			priority if (hit_q) begin
				status_q <= ST_KNOWN;
				number_q <= '0;
			end else if (mac_bad) begin
				status_q <= ST_REJECT;
				number_q <= '0;
			end else if (is_full) begin
				status_q <= ST_FULL;
				number_q <= '0;
			end else begin
				status_q <= ST_ADDED;
				number_q <= num_wide[ENTRY_W-1:0];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_number = number_q;

endmodule

// ===== hdl/arp_binding_learn_table.sv =====
// An accepted beat is scanned against the filled entries, then decided; the decision waits
// while the output register holds an untaken result. One beat is handled at a time; the scan reads one
// entry per cycle through a single registered memory port and one 32-bit comparator.
// The input is taken again as soon as the result is loaded into the output register.
// Reset clears the fill count and the handshake state; table contents are not cleared,
// since only filled entries are ever read.
module arp_binding_learn_table #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [abl_pkg::IP_W-1:0]    ipv4_addr,
	input  logic [abl_pkg::MAC_W-1:0]   mac_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output abl_pkg::status_t            status,
	output logic [abl_pkg::ENTRY_W-1:0] entry_number
);
	import abl_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IP_W-1:0]  wr_ip;
	logic [MAC_W-1:0] wr_mac;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [IP_W-1:0]  rd_ip;

	// Scan and decision sequencer.
	abl_seq #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ipv4_addr    (ipv4_addr),
		.mac_addr     (mac_addr),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entry_number (entry_number),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_ip        (wr_ip),
		.wr_mac       (wr_mac),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_ip        (rd_ip)
	);

	// Binding storage.
	abl_mem #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_ip   (wr_ip),
		.wr_mac  (wr_mac),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_ip   (rd_ip)
	);

endmodule

// ===== tb/sv/arp_binding_learn_table_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ARP binding learn table, with its own prediction of the table.
module arp_binding_learn_table_tb;
	import abl_pkg::*;

	localparam int unsigned DEPTH    = 256;
	localparam int unsigned N_ITEMS  = 1650;
	localparam int unsigned SHOW_MAX = 10;
	localparam int unsigned N_DIR    = 14;

	typedef logic [IP_W-1:0]    ip_t;
	typedef logic [MAC_W-1:0]   mac_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		status_t status;
		entry_t  number;
	} reply_t;

	// Directed beats: field extremes, non-full statuses, known-before-reject priority, near misses.
	localparam ip_t DIR_IP [N_DIR] = '{
		32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
		32'h0000_0001, 32'h8000_0000, 32'hC0A8_0001, 32'hC0A8_0101
	};
	localparam mac_t DIR_MAC [N_DIR] = '{
		48'h00FF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 48'h0100_0000_0000,
		48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 48'h8000_0000_0000, 48'hFF00_0000_0000,
		48'h7FFF_FFFF_FFFF, 48'h00FF_FFFF_FFFF, 48'h0000_0000_0000, 48'h0000_0000_0000,
		48'h0200_0000_0000, 48'hFE12_3456_789A
	};

	// Mirror of the learned table and the queue of replies still owed by the block.
	class binding_tracker;
		ip_t         learned_ip[$];
		reply_t      pending[$];
		int unsigned failures;
		int unsigned replies;
		int unsigned seen[4];

		// Predict the reply to one accepted request and update the mirrored table.
		function void note_request(ip_t ip, mac_t mac);
			reply_t r;
			bit     known;
			known = 1'b0;
			foreach (learned_ip[k])
				if (learned_ip[k] == ip) known = 1'b1;
			r.number = '0;
			if (known) begin
				r.status = ST_KNOWN;
			end else if (mac[MAC_W-1 -: 8] == MAC_BAD_BYTE) begin
				r.status = ST_REJECT;
			end else if (learned_ip.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				learned_ip.push_back(ip);
				r.status = ST_ADDED;
				r.number = entry_t'(learned_ip.size());
			end
			pending.push_back(r);
		endfunction

		// Compare one result beat with the oldest owed reply.
		function void check_reply(status_t st, entry_t num);
			reply_t want;
			replies++;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= SHOW_MAX)
					$display("%0t: result with none owed: status=%0d entry=%0d", $time, st, num);
				return;
			end
			want = pending.pop_front();
			seen[want.status]++;
			if (st !== want.status || num !== want.number) begin
				failures++;
				if (failures <= SHOW_MAX)
					$display("%0t: result %0d: expected status=%0d entry=%0d, got status=%0d entry=%0d",
						$time, replies, want.status, want.number, st, num);
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	ip_t    ipv4_addr;
	mac_t   mac_addr;
	logic   out_valid;
	logic   out_stall;
	status_t status;
	entry_t entry_number;

	binding_tracker board = new();
	int unsigned    burst_left;
	int unsigned    sent;

	arp_binding_learn_table #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ipv4_addr(ipv4_addr),
		.mac_addr(mac_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_number(entry_number)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls in segments: none, light, heavy or a fixed stripe.
	initial begin : receiver
		int unsigned mode;
		int unsigned left;
		out_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(40, 400);
			end
			left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((left % 5) < 2);
			endcase
		end
	end

	// Every result beat is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_reply(status, entry_number);
	end

	// Hard limit on the whole run.
	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Random MAC with a usable or a zero first byte.
	function automatic mac_t rand_mac(bit usable);
		mac_t mac;
		mac = mac_t'({$urandom, $urandom});
		if (usable) begin
			if (mac[MAC_W-1 -: 8] == MAC_BAD_BYTE)
				mac[MAC_W-1 -: 8] = 8'($urandom_range(1, 255));
		end else begin
			mac[MAC_W-1 -: 8] = MAC_BAD_BYTE;
		end
		return mac;
	endfunction

	// An address already in the table, or a random one while the table is empty.
	function automatic ip_t pick_known();
		if (board.learned_ip.size() == 0)
			return ip_t'($urandom);
		return board.learned_ip[$urandom_range(0, board.learned_ip.size() - 1)];
	endfunction

	// Drive one request beat, wait for it to be taken, then idle between bursts.
	task automatic send_beat(input ip_t ip, input mac_t mac);
		int unsigned gap;
		in_valid  <= 1'b1;
		ipv4_addr <= ip;
		mac_addr  <= mac;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(ip, mac);
		sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 10);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Hold the sender off until every owed reply has come back.
	task automatic drain_replies();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (board.pending.size() != 0);
		burst_left = 0;
	endtask

	// Request stream: directed beats, a fill phase, then traffic against a full table.
	initial begin : stimulus
		int unsigned pick;
		in_valid   = 1'b0;
		ipv4_addr  = '0;
		mac_addr   = '0;
		arst_n     = 1'b0;
		burst_left = 0;
		sent       = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_beat(DIR_IP[i], DIR_MAC[i]);
		drain_replies();

		// Fill the table, mostly with new usable pairs.
		while (board.learned_ip.size() < DEPTH) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_beat(ip_t'($urandom), rand_mac(1'b1));
			else if (pick < 75)
				send_beat(ip_t'($urandom), rand_mac(1'b0));
			else if (pick < 95)
				send_beat(pick_known(), rand_mac(1'($urandom_range(0, 1))));
			else
				send_beat(pick_known() ^ (ip_t'(1) << $urandom_range(0, 31)),
					rand_mac(1'($urandom_range(0, 1))));
		end
		drain_replies();

		// Table full: known hits, overflow attempts, rejects and near misses.
		while (sent < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_beat(pick_known(), rand_mac(1'($urandom_range(0, 1))));
			else if (pick < 70)
				send_beat(ip_t'($urandom), rand_mac(1'b1));
			else if (pick < 85)
				send_beat(ip_t'($urandom), rand_mac(1'b0));
			else
				send_beat(pick_known() ^ (ip_t'(1) << $urandom_range(0, 31)),
					rand_mac(1'($urandom_range(0, 1))));
		end
		drain_replies();
		repeat (DEPTH + 8) @(posedge clk);

		$display("Run covered %0d requests: %0d known, %0d added, %0d rejected, %0d with the table full.",
			sent, board.seen[ST_KNOWN], board.seen[ST_ADDED], board.seen[ST_REJECT],
			board.seen[ST_FULL]);
		$display("Table ended with %0d entries; %0d results checked, %0d failures.",
			board.learned_ip.size(), board.replies, board.failures);
		if (board.failures == 0 && board.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
